[rtl/core/ede_pkg.sv]
// Shared constants and the queue entry type of the Elias delta encoder.
// No dependencies; every other file of the block imports this package.
package ede_pkg;

    // Width of the coded value; the offset sum wraps at this width
    localparam int VALUE_WIDTH = 32;
    localparam int IN_W        = 32;
    localparam int OFFSET_W    = 32;
    localparam int BYTE_W      = 8;

    // floor(log2 v) and floor(log2(N+1)) widths
    localparam int NW   = $clog2(VALUE_WIDTH);
    localparam int L_W  = $clog2(NW + 1);
    localparam int LMAX = $clog2(VALUE_WIDTH + 1) - 1;

    // Right-aligned code word without its leading zeros: (N+1) << N | low bits
    localparam int CODE_W  = VALUE_WIDTH + NW;
    localparam int MAX_LEN = 2 * LMAX + VALUE_WIDTH;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);

    // Left-aligned bit accumulator: pending bits plus one whole code word
    localparam int ACC_W = MAX_LEN + BYTE_W - 1;
    localparam int CNT_W = $clog2(ACC_W + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              err;
        logic              last;
    } t_item;

endpackage

[rtl/core/ede_front.sv]
// Front end: offset register, input stage and code word classification.
// Depends on ede_pkg; feeds classified items into ede_queue.
module ede_front import ede_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [IN_W-1:0]     i_value,
    input  logic                i_last,
    input  logic                i_cfg_valid,
    input  logic [OFFSET_W-1:0] i_cfg_value_offset,
    input  logic                i_q_full,
    output logic                o_q_push,
    output t_item               o_q_item
);

    function automatic logic [NW-1:0] flog2_v(input logic [VALUE_WIDTH-1:0] v);
        logic [NW-1:0] r;
        r = '0;
        for (int i = 1; i < VALUE_WIDTH; i++) begin
            if (v[i]) begin
                r = NW'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [L_W-1:0] flog2_n(input logic [NW:0] x);
        logic [L_W-1:0] r;
        r = '0;
        for (int i = 1; i <= NW; i++) begin
            if (x[i]) begin
                r = L_W'(i);
            end
        end
        return r;
    endfunction

    logic [OFFSET_W-1:0]    r_offset;
    logic                   r_s_valid;
    logic [VALUE_WIDTH-1:0] r_s_v;
    logic                   r_s_last;

    logic [VALUE_WIDTH-1:0] in_v;
    logic [VALUE_WIDTH-1:0] off_v;
    logic [NW-1:0]          nb;
    logic [NW:0]            nb1;
    logic [L_W-1:0]         lb;
    logic [VALUE_WIDTH-1:0] low;

    assign o_in_ready = !r_s_valid || !i_q_full;
    assign in_v       = VALUE_WIDTH'(i_value);
    assign off_v      = VALUE_WIDTH'($signed(r_offset));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_s_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_offset <= i_cfg_value_offset;
            end
            if (o_in_ready) begin
                r_s_valid <= i_in_valid;
            end
        end
    end

    // Add the offset on accept, wrap at the value width
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s_v    <= in_v + off_v;
            r_s_last <= i_last;
        end
    end

    always_comb begin
        nb  = flog2_v(r_s_v);
        nb1 = {1'b0, nb} + (NW+1)'(1);
        lb  = flog2_n(nb1);
        // drop the implied leading one
        low = r_s_v ^ (VALUE_WIDTH'(1) << nb);

        o_q_push      = r_s_valid && !i_q_full;
        o_q_item.last = r_s_last;
        o_q_item.err  = (r_s_v == '0);
        if (o_q_item.err) begin
            o_q_item.code = '0;
            o_q_item.len  = '0;
        end else begin
            o_q_item.code = (CODE_W'(nb1) << nb) | CODE_W'(low);
            o_q_item.len  = LEN_W'({lb, 1'b0}) + LEN_W'(nb) + LEN_W'(1);
        end
    end

endmodule

[rtl/core/ede_queue.sv]
// Short queue of classified code words between front and back end.
// Depends on ede_pkg for the entry type and depth.
module ede_queue import ede_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

[rtl/core/ede_back.sv]
// Back end: bit accumulator that packs code words into bytes, one per cycle
// unless stalled; also end-of-stream flush, output register. Uses ede_pkg.
module ede_back import ede_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_item             i_q_item,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_run_end,
    output logic              o_stream_end,
    output logic              o_error
);

    // pending bits stay left-aligned in r_acc between items
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_err, n_err;
    logic              r_last, n_last;

    logic              r_ov;
    logic [BYTE_W-1:0] r_ob;
    logic              r_ore, r_ose, r_oer;

    logic              out_free, load, act;
    logic [CNT_W-1:0]  amt, cur_cnt, rem;
    logic [ACC_W-1:0]  cur_acc;
    logic              cur_err, cur_last;
    logic              emit, more;
    logic [BYTE_W-1:0] e_byte;
    logic              e_err;

    always_comb begin
        out_free = !r_ov || i_out_ready;
        load     = !r_busy && i_q_valid;
        act      = out_free && (r_busy || i_q_valid);
        o_q_pop  = load && out_free;

        amt      = CNT_W'(ACC_W) - r_cnt - CNT_W'(i_q_item.len);
        cur_acc  = load ? (r_acc | (ACC_W'(i_q_item.code) << amt)) : r_acc;
        cur_cnt  = load ? (r_cnt + CNT_W'(i_q_item.len)) : r_cnt;
        cur_err  = load ? i_q_item.err : r_err;
        cur_last = load ? i_q_item.last : r_last;
        rem      = cur_cnt - CNT_W'(BYTE_W);

        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_err  = r_err;
        n_last = r_last;
        emit   = 1'b0;
        more   = 1'b0;
        e_byte = '0;
        e_err  = 1'b0;

        if (act) begin
            n_last = cur_last;
            n_err  = 1'b0;
            if (cur_err) begin
                emit  = 1'b1;
                e_err = 1'b1;
                more  = cur_last && (cur_cnt != '0);
                n_acc = cur_acc;
                n_cnt = cur_cnt;
            end else if (cur_cnt >= CNT_W'(BYTE_W)) begin
                emit   = 1'b1;
                e_byte = cur_acc[ACC_W-1 -: BYTE_W];
                more   = (rem >= CNT_W'(BYTE_W)) || (cur_last && (rem != '0));
                n_acc  = cur_acc << BYTE_W;
                n_cnt  = rem;
            end else if (cur_last && (cur_cnt != '0)) begin
                // flush the partial byte, low bits are already zero
                emit   = 1'b1;
                e_byte = cur_acc[ACC_W-1 -: BYTE_W];
                n_acc  = '0;
                n_cnt  = '0;
            end else begin
                // item only adds pending bits
                n_acc = cur_acc;
                n_cnt = cur_cnt;
            end
            n_busy = more;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_err  <= 1'b0;
            r_last <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_err  <= n_err;
            r_last <= n_last;
            if (out_free) begin
                r_ov <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && emit) begin
            r_ob  <= e_byte;
            r_oer <= e_err;
            r_ore <= !more;
            r_ose <= !more && cur_last;
        end
    end

    assign o_out_valid  = r_ov;
    assign o_out_byte   = r_ob;
    assign o_run_end    = r_ore;
    assign o_stream_end = r_ose;
    assign o_error      = r_oer;

endmodule

[rtl/core/elias_delta_encoder.sv]
// Elias delta encoder. Each accepted value gets the signed offset added (wrapping at
// 32 bits) and is coded as L zeros, N+1 in L+1 bits and the low N bits of the value,
// packed MSB-first into bytes. An item passes the input register and the queue
// before it reaches the packer; the packer then sends one result byte per cycle
// while the output is not stalled: zero to six code bytes, or one error byte for
// a zero result, plus one byte for the end-of-stream flush. A four-entry queue
// lets the input keep taking items while the packer drains bytes. Write the
// offset only while the block is idle.
module elias_delta_encoder import ede_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [IN_W-1:0]     i_value,
    input  logic                i_last,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [BYTE_W-1:0]   o_out_byte,
    output logic                o_run_end,
    output logic                o_stream_end,
    output logic                o_error,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [OFFSET_W-1:0] i_cfg_value_offset
);

    logic  q_full, q_push, q_pop, q_valid;
    t_item q_in_item, q_out_item;

    assign o_cfg_ready = 1'b1;

    ede_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_value            (i_value),
        .i_last             (i_last),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_value_offset (i_cfg_value_offset),
        .i_q_full           (q_full),
        .o_q_push           (q_push),
        .o_q_item           (q_in_item)
    );

    ede_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_out_item)
    );

    ede_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_item     (q_out_item),
        .o_q_pop      (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_run_end    (o_run_end),
        .o_stream_end (o_stream_end),
        .o_error      (o_error)
    );

endmodule
